### sv/aucv_pkg.sv
`default_nettype none
package aucv_pkg;

  localparam int STAGES         = 7;
  localparam int IFB            = 30;
  localparam int FRAC_BITS_DEF  = 32;
  localparam int TABLE_BITS_DEF = 10;

  localparam logic [63:0] ONE30 = 64'd1 << IFB;

  // log-domain constants, Q30
  localparam logic [31:0] BASE_L2 = 32'd3254897708;
  localparam logic [32:0] P2DB_K  = 33'd3232284966;
  localparam logic [32:0] R2DB_K  = 33'd6464569932;
  localparam logic [32:0] DB2P_K  = 33'd356689313;
  localparam logic [32:0] DB2R_K  = 33'd178344657;

  localparam int NOTE_LO    = 1500;
  localparam int NOTE_HI    = 1499;
  localparam int POW_DB_MAX = 870;
  localparam int RMS_DB_MAX = 485;
  localparam int DB_REF     = 100;

  // reciprocals of 3 for a split 39-bit divide
  localparam logic [18:0] DIV3_M20 = 19'd349526;
  localparam logic [21:0] DIV3_M23 = 22'd2796203;

  localparam logic [2:0] REQ_MTOF    = 3'd0;
  localparam logic [2:0] REQ_FTOM    = 3'd1;
  localparam logic [2:0] REQ_POWTODB = 3'd2;
  localparam logic [2:0] REQ_DBTOPOW = 3'd3;
  localparam logic [2:0] REQ_RMSTODB = 3'd4;
  localparam logic [2:0] REQ_DBTORMS = 3'd5;

  typedef struct packed {
    logic [2:0] req;
    logic       vpos;
    logic       nlow;
  } ctl_t;

  // (a * k) >> 30 in two halves, magnitude only
  function automatic logic [59:0] mulk_hi(input logic [41:0] ua, input logic [32:0] k);
    return ua[41:15] * k;
  endfunction

  function automatic logic [47:0] mulk_lo(input logic [41:0] ua, input logic [32:0] k);
    return ua[14:0] * k;
  endfunction

  function automatic logic [45:0] mulk_fin(input logic [59:0] p1, input logic [47:0] p2);
    logic [60:0] p;
    p = 61'(p1) + 61'(p2 >> 15);
    return 46'(p >> 15);
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] n0);
    logic [63:0] n, res, bt;
    n   = n0;
    res = 64'd0;
    bt  = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (bt > n) bt = bt >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (bt != 64'd0) begin
        if (n >= res + bt) begin
          n   = n - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // log2(1 + i/2^tb), Q30
  function automatic logic [31:0] rom_log2(input int tb, input int i);
    logic [63:0] m, y;
    if (i >= (1 << tb)) return 32'(ONE30);
    m = (64'(1 << tb) + 64'(i)) << (IFB - tb);
    y = 64'd0;
    for (int k = 1; k <= IFB; k++) begin
      m = (m * m) >> IFB;
      if (m >= 2 * ONE30) begin
        m = m >> 1;
        y = y | (ONE30 >> k);
      end
    end
    return 32'(y);
  endfunction

  // 2^(i/2^tb), Q30
  function automatic logic [31:0] rom_exp2(input int tb, input int i);
    logic [63:0] r, m;
    r = 2 * ONE30;
    m = ONE30;
    if (i >= (1 << tb)) return 32'(2 * ONE30);
    for (int k = 1; k <= 14; k++) begin
      if (k <= tb) begin
        r = isqrt64(r << IFB);
        if (((i >> (tb - k)) & 1) != 0) m = (m * r) >> IFB;
      end
    end
    return 32'(m);
  endfunction

endpackage
`default_nettype wire

### sv/audio_unit_converter.sv
`default_nettype none
// Channel  Dir  Signals                      Payload
// s_       in   s_tvalid s_tready s_tdata    tdata: value_in[63:0]; tuser: req_type[2:0]
//                         s_tuser
// m_       out  m_tvalid m_tready m_tdata    tdata: value_out[63:0]; tuser: saturated[0]
//                         m_tuser
//
// Seven register stages; one transfer per cycle sustained while the output
// is not stalled.
// Each stage holds its item until the next stage is free, so bubbles close up and
// a stalled output backs up one stage at a time.
// rst (synchronous) clears the valid bits only; the tables are constants.
module audio_unit_converter #(
  parameter int FRAC_BITS  = aucv_pkg::FRAC_BITS_DEF,
  parameter int TABLE_BITS = aucv_pkg::TABLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // value_in[63:0]
  input  wire logic [2:0]  s_tuser,   // req_type[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // value_out[63:0]
  output logic [0:0]       m_tuser    // saturated[0]
);

  localparam int ST = aucv_pkg::STAGES;
  localparam logic signed [63:0] NOTE_FLOOR =
    -($signed(64'(aucv_pkg::NOTE_LO)) <<< FRAC_BITS);
  localparam logic [63:0] SAT_MAX = {1'b0, {63{1'b1}}};

  logic [ST:1] vld, en;
  aucv_pkg::ctl_t ctl_in;
  aucv_pkg::ctl_t ctl [1:ST-1];

  logic signed [41:0] l4;
  logic [31:0]        m6;
  logic signed [12:0] s6, sn;
  logic [63:0]        r_log6;
  logic [63:0]        exp_val, val;
  logic               exp_sat, sat;

  always_comb begin
    en[ST] = !vld[ST] || m_tready;
    for (int k = ST - 1; k >= 1; k--) en[k] = !vld[k] || en[k+1];
  end

  assign s_tready = en[1];
  assign m_tvalid = vld[ST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= s_tvalid;
      for (int k = 2; k <= ST; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_comb begin
    ctl_in.req  = s_tuser;
    ctl_in.vpos = !s_tdata[63] && (|s_tdata[62:0]);
    ctl_in.nlow = $signed(s_tdata) <= NOTE_FLOOR;
  end

  always_ff @(posedge clk) begin
    if (en[1]) ctl[1] <= ctl_in;
    for (int k = 2; k <= ST - 1; k++) begin
      if (en[k]) ctl[k] <= ctl[k-1];
    end
  end

  aucv_exparg #(.FRAC_BITS(FRAC_BITS)) u_exparg (
    .clk      (clk),
    .en       (en),
    .value_in (s_tdata),
    .req_type (s_tuser),
    .l_out    (l4)
  );

  aucv_exp2 #(.FRAC_BITS(FRAC_BITS), .TABLE_BITS(TABLE_BITS)) u_exp2 (
    .clk   (clk),
    .en    (en),
    .l_in  (l4),
    .m_out (m6),
    .s_out (s6)
  );

  aucv_log2 #(.FRAC_BITS(FRAC_BITS), .TABLE_BITS(TABLE_BITS)) u_log2 (
    .clk      (clk),
    .en       (en),
    .value_in (s_tdata),
    .req_type (s_tuser),
    .r_log    (r_log6)
  );

  // final exp2 scaling: saturate high, flush low
  always_comb begin
    sn      = -s6;
    exp_val = 64'd0;
    exp_sat = 1'b0;
    if (s6 >= 33) begin
      exp_sat = 1'b1;
      exp_val = SAT_MAX;
    end else if (s6 >= 0) begin
      exp_val = 64'(m6) << s6[5:0];
    end else if (s6 > -32) begin
      exp_val = 64'(m6) >> sn[5:0];
    end
  end

  always_comb begin
    val = 64'd0;
    sat = 1'b0;
    case (ctl[ST-1].req)
      aucv_pkg::REQ_MTOF: begin
        if (!ctl[ST-1].nlow) begin
          val = exp_val;
          sat = exp_sat;
        end
      end
      aucv_pkg::REQ_FTOM: begin
        val = ctl[ST-1].vpos ? r_log6 : NOTE_FLOOR;
      end
      aucv_pkg::REQ_POWTODB, aucv_pkg::REQ_RMSTODB: begin
        if (ctl[ST-1].vpos) val = r_log6;
      end
      aucv_pkg::REQ_DBTOPOW, aucv_pkg::REQ_DBTORMS: begin
        if (ctl[ST-1].vpos) begin
          val = exp_val;
          sat = exp_sat;
        end
      end
      default: begin
        val = 64'd0;
        sat = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[ST]) begin
      m_tdata    <= val;
      m_tuser[0] <= sat;
    end
  end

endmodule
`default_nettype wire

### sv/aucv_exparg.sv
`default_nettype none
// Builds the Q30 exponent for mtof / dbtopow / dbtorms over stages 1..4.
module aucv_exparg #(
  parameter int FRAC_BITS = aucv_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic [aucv_pkg::STAGES:1]     en,
  input  wire logic [63:0]                   value_in,
  input  wire logic [2:0]                    req_type,
  output logic signed [41:0]                 l_out
);

  localparam int UP = (FRAC_BITS >= aucv_pkg::IFB) ? FRAC_BITS - aucv_pkg::IFB : 0;
  localparam int DN = (FRAC_BITS >= aucv_pkg::IFB) ? 0 : aucv_pkg::IFB - FRAC_BITS;

  localparam logic signed [63:0] NOTE_TOP = $signed(64'(aucv_pkg::NOTE_HI)) <<< FRAC_BITS;
  localparam logic signed [63:0] POW_CAP  = $signed(64'(aucv_pkg::POW_DB_MAX)) <<< FRAC_BITS;
  localparam logic signed [63:0] RMS_CAP  = $signed(64'(aucv_pkg::RMS_DB_MAX)) <<< FRAC_BITS;
  localparam logic signed [63:0] DB_Q30   = $signed(64'(aucv_pkg::DB_REF)) <<< aucv_pkg::IFB;

  logic signed [63:0] v, vm, vd, cap, qm, qd, x;
  logic               mt_in, rms_in;

  logic [41:0] s1_mag;
  logic        s1_neg, s1_mt, s1_rms;

  logic [38:0] n;
  logic [37:0] ph;
  logic [32:0] k;
  logic [17:0] s2_qh;
  logic [1:0]  s2_rh;
  logic [19:0] s2_nl;
  logic [59:0] s2_p1;
  logic [47:0] s2_p2;
  logic        s2_neg, s2_mt;

  logic [21:0] n2;
  logic [43:0] pq;
  logic [37:0] s3_q;
  logic [45:0] s3_r;
  logic        s3_neg, s3_mt;

  logic signed [41:0] qv, rv;

  assign v      = $signed(value_in);
  assign mt_in  = (req_type == aucv_pkg::REQ_MTOF);
  assign rms_in = (req_type == aucv_pkg::REQ_DBTORMS);

  always_comb begin
    vm  = (v > NOTE_TOP) ? NOTE_TOP : v;
    cap = rms_in ? RMS_CAP : POW_CAP;
    vd  = (v > cap) ? cap : v;
    qm  = (vm <<< DN) >>> UP;
    qd  = ((vd <<< DN) >>> UP) - DB_Q30;
    x   = mt_in ? qm : qd;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_mag <= x[63] ? 42'(-x) : 42'(x);
      s1_neg <= x[63];
      s1_mt  <= mt_in;
      s1_rms <= rms_in;
    end
  end

  // stage 2: the /12 of the upper 19 bits, and the two partial products
  always_comb begin
    n  = s1_mag[40:2];
    ph = {19'd0, n[38:20]} * 38'(aucv_pkg::DIV3_M20);
    k  = s1_rms ? aucv_pkg::DB2R_K : aucv_pkg::DB2P_K;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_qh  <= ph[37:20];
      s2_rh  <= 2'(n[38:20] - {ph[37:20], 1'b0} - {1'b0, ph[37:20]});
      s2_nl  <= n[19:0];
      s2_p1  <= aucv_pkg::mulk_hi(s1_mag, k);
      s2_p2  <= aucv_pkg::mulk_lo(s1_mag, k);
      s2_neg <= s1_neg;
      s2_mt  <= s1_mt;
    end
  end

  always_comb begin
    n2 = {s2_rh, s2_nl};
    pq = 44'(n2) * 44'(aucv_pkg::DIV3_M23);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_q   <= {s2_qh, 20'd0} + 38'(pq[43:23]);
      s3_r   <= aucv_pkg::mulk_fin(s2_p1, s2_p2);
      s3_neg <= s2_neg;
      s3_mt  <= s2_mt;
    end
  end

  always_comb begin
    qv = $signed({4'd0, s3_q});
    rv = $signed({1'b0, s3_r[40:0]});
    if (s3_neg) begin
      qv = -qv;
      rv = -rv;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      l_out <= s3_mt ? qv + $signed({10'd0, aucv_pkg::BASE_L2}) : rv;
    end
  end

endmodule
`default_nettype wire

### sv/aucv_exp2.sv
`default_nettype none
// 2^l: table lookup with interpolation, stages 5..6. Shift is done downstream.
module aucv_exp2 #(
  parameter int FRAC_BITS  = aucv_pkg::FRAC_BITS_DEF,
  parameter int TABLE_BITS = aucv_pkg::TABLE_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic [aucv_pkg::STAGES:1] en,
  input  wire logic signed [41:0]        l_in,
  output logic [31:0]                    m_out,
  output logic signed [12:0]             s_out
);

  localparam int ROM_N = (1 << TABLE_BITS) + 1;
  localparam int RW    = aucv_pkg::IFB - TABLE_BITS;

  typedef logic [31:0] rom_t [ROM_N];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < ROM_N; k++) r[k] = aucv_pkg::rom_exp2(TABLE_BITS, k);
    return r;
  endfunction

  localparam rom_t EROM = build_rom();

  logic [TABLE_BITS:0] idx, idx1;
  logic [31:0]         a, b;
  logic [RW-1:0]       rem;
  logic signed [12:0]  s5;
  logic [63:0]         prod;

  assign idx  = {1'b0, l_in[aucv_pkg::IFB-1:RW]};
  assign idx1 = idx + 1'b1;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      a   <= EROM[idx];
      b   <= EROM[idx1];
      rem <= l_in[RW-1:0];
      // integer part of l is signed
      s5  <= 13'($signed(l_in[41:aucv_pkg::IFB])) + 13'(FRAC_BITS - aucv_pkg::IFB);
    end
  end

  assign prod = 64'(b - a) * 64'(rem);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      m_out <= a + ((b > a) ? 32'(prod >> RW) : 32'd0);
      s_out <= s5;
    end
  end

endmodule
`default_nettype wire

### sv/aucv_log2.sv
`default_nettype none
// log2 of the operand and the ftom / powtodb / rmstodb scaling, stages 1..6.
module aucv_log2 #(
  parameter int FRAC_BITS  = aucv_pkg::FRAC_BITS_DEF,
  parameter int TABLE_BITS = aucv_pkg::TABLE_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic [aucv_pkg::STAGES:1] en,
  input  wire logic [63:0]               value_in,
  input  wire logic [2:0]                req_type,
  output logic [63:0]                    r_log
);

  localparam int ROM_N = (1 << TABLE_BITS) + 1;
  localparam int UP = (FRAC_BITS >= aucv_pkg::IFB) ? FRAC_BITS - aucv_pkg::IFB : 0;
  localparam int DN = (FRAC_BITS >= aucv_pkg::IFB) ? 0 : aucv_pkg::IFB - FRAC_BITS;
  localparam logic signed [47:0] DB_Q30 = $signed(48'(aucv_pkg::DB_REF)) <<< aucv_pkg::IFB;

  typedef logic [31:0] rom_t [ROM_N];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < ROM_N; k++) r[k] = aucv_pkg::rom_log2(TABLE_BITS, k);
    return r;
  endfunction

  localparam rom_t LROM = build_rom();

  logic [5:1] ftom;
  logic [4:1] rms;

  logic [62:0] s1_v, s2_v, u;
  logic [5:0]  p, s2_p, s3_p;
  logic [TABLE_BITS:0] idx, idx1;
  logic [31:0] a, b;
  logic [29:0] rem;
  logic [63:0] prod;
  logic [31:0] lf;
  logic signed [39:0] ex, s4_l;
  logic signed [43:0] d, t;
  logic [41:0] ua;
  logic [63:0] s5_ft;
  logic [32:0] k;
  logic [59:0] s5_p1;
  logic [47:0] s5_p2;
  logic        s5_neg;
  logic [45:0] r;
  logic signed [47:0] rv, g;
  logic [63:0] res;

  // type flags travel alongside the data
  always_ff @(posedge clk) begin
    if (en[1]) begin
      ftom[1] <= (req_type == aucv_pkg::REQ_FTOM);
      rms[1]  <= (req_type == aucv_pkg::REQ_RMSTODB);
    end
    for (int j = 2; j <= 5; j++) begin
      if (en[j]) ftom[j] <= ftom[j-1];
    end
    for (int j = 2; j <= 4; j++) begin
      if (en[j]) rms[j] <= rms[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) s1_v <= value_in[62:0];
  end

  // leading-one detect
  always_comb begin
    p = 6'd0;
    for (int j = 0; j < 63; j++) begin
      if (s1_v[j]) p = 6'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_v <= s1_v;
      s2_p <= p;
    end
  end

  always_comb begin
    u    = s2_v << (6'd62 - s2_p);
    idx  = {1'b0, u[61:62-TABLE_BITS]};
    idx1 = idx + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      a    <= LROM[idx];
      b    <= LROM[idx1];
      rem  <= u[61-TABLE_BITS:32-TABLE_BITS];
      s3_p <= s2_p;
    end
  end

  always_comb begin
    prod = 64'(b - a) * 64'(rem);
    lf   = a + ((b > a) ? 32'(prod >> aucv_pkg::IFB) : 32'd0);
    ex   = $signed({34'd0, s3_p}) - 40'(FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en[4]) s4_l <= (ex <<< aucv_pkg::IFB) + $signed({8'd0, lf});
  end

  always_comb begin
    d  = 44'(s4_l) - $signed({12'd0, aucv_pkg::BASE_L2});
    t  = (d <<< 3) + (d <<< 2);
    ua = 42'(s4_l[39] ? -s4_l : s4_l);
    k  = rms[4] ? aucv_pkg::R2DB_K : aucv_pkg::P2DB_K;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_ft  <= 64'((64'(t) <<< UP) >>> DN);
      s5_p1  <= aucv_pkg::mulk_hi(ua, k);
      s5_p2  <= aucv_pkg::mulk_lo(ua, k);
      s5_neg <= s4_l[39];
    end
  end

  always_comb begin
    r   = aucv_pkg::mulk_fin(s5_p1, s5_p2);
    rv  = $signed({2'd0, r});
    g   = DB_Q30 + (s5_neg ? -rv : rv);
    res = g[47] ? 64'd0 : 64'((64'(g) <<< UP) >>> DN);
  end

  always_ff @(posedge clk) begin
    if (en[6]) r_log <= ftom[5] ? s5_ft : res;
  end

endmodule
`default_nettype wire

### sv/aucv_checker.sv
`default_nettype none
module aucv_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [63:0] s_tdata,
  input wire logic [2:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata,
  input wire logic [0:0]  m_tuser
);

  // a result waiting for a transfer keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == {1'b0, {63{1'b1}}})
    else $error("saturated flag without max value");

  // an empty output stage means the whole pipe can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind audio_unit_converter aucv_checker u_aucv_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
